// File: rtl/pli_pkg.sv
`timescale 1ns / 1ps

package pli_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int DATA_W         = 32;
  localparam int COUNT_W        = 5;
  localparam int IN_TDATA_W     = 104;
  localparam int QUEUE_DEPTH    = 2;
  localparam int DIV_BITS       = 2;
  localparam int DIV_STEPS      = 64 / DIV_BITS;

  localparam logic REG_POINT_COUNT = 1'b0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                    kind;
    logic [3:0]                 idx;
    logic signed [DATA_W-1:0]   px;
    logic signed [DATA_W-1:0]   py;
    logic signed [DATA_W-1:0]   qx;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIFF,
    ST_MAG,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } back_state_t;

endpackage

// File: rtl/piecewise_linear_table_interpolator.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload
// s_*       in   tuser: opcode; tdata: point_index, point_x, point_y, query_x
// m_*       out  tuser: saturated; tdata: result_y
// apb       in   register 0 at byte address 0: point_count
//
// A write word is written to the breakpoint RAM in the cycle it is popped.
// A query scans the table one breakpoint a cycle; where it interpolates,
// the divider gives two quotient bits a cycle.
// A two-word queue decouples input from the back end; results wait in a
// register. Reset clears control state; the table is undefined until written.

module piecewise_linear_table_interpolator import pli_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // point_index[3:0], point_x[35:4], point_y[67:36], query_x[99:68], zero pad
  input  logic [IN_TDATA_W-1:0] s_tdata,
  // opcode
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // result_y[31:0]
  output logic [DATA_W-1:0]     m_tdata,
  // saturated
  output logic                  m_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [COUNT_W-1:0] point_count;
  logic               q_valid;
  cmd_t               q_cmd;
  logic               q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POINT_COUNT) ? 32'(point_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_POINT_COUNT)) begin
      point_count <= pwdata[COUNT_W-1:0];
    end
  end

  pli_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  pli_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .point_count (point_count),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

// File: rtl/pli_ram.sv
`timescale 1ns / 1ps

module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pli_div.sv
`timescale 1ns / 1ps

module pli_div import pli_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      rem;
  logic [63:0]      quo;
  logic [31:0]      dvs;
  logic [31:0]      rem_next;
  logic [63:0]      quo_next;

  // Restoring division, DIV_BITS quotient bits per cycle.
  always_comb begin
    logic [32:0] wide;
    logic        ge;
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < DIV_BITS; k++) begin
      wide     = {rem_next, quo_next[63]};
      ge       = (wide >= {1'b0, dvs});
      quo_next = {quo_next[62:0], ge};
      rem_next = ge ? 32'(wide - {1'b0, dvs}) : wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/pli_front.sv
`timescale 1ns / 1ps

module pli_front import pli_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tuser,
  output logic                  q_valid,
  output cmd_t                  q_cmd,
  input  logic                  q_pop
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  cmd_t              cmd_in;
  logic              keep;
  logic              push;

  assign cmd_in.kind = opcode_t'(s_tuser);
  assign cmd_in.idx  = s_tdata[3:0];
  assign cmd_in.px   = s_tdata[35:4];
  assign cmd_in.py   = s_tdata[67:36];
  assign cmd_in.qx   = s_tdata[99:68];

  // A write to a slot past the table is dropped here.
  assign keep     = (cmd_in.kind == OP_QUERY) || (32'(cmd_in.idx) < MAX_POINTS);
  assign s_tready = (fill != FILL_W'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready && keep;
  assign q_valid  = (fill != '0);
  assign q_cmd    = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !q_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (!push && q_pop) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

endmodule

// File: rtl/pli_back.sv
`timescale 1ns / 1ps

module pli_back import pli_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] point_count,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [DATA_W-1:0]  m_tdata,
  output logic               m_tuser
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic signed [34:0] SUM_MAX = 35'sh0_7FFF_FFFF;
  localparam logic signed [34:0] SUM_MIN = 35'sh7_8000_0000;
  localparam logic [63:0]        Q_LIMIT = 64'h2_0000_0000;

  back_state_t state;
  back_state_t state_next;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [2*DATA_W-1:0]      ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [2*DATA_W-1:0]      ram_rdata;
  logic signed [DATA_W-1:0] rx;
  logic signed [DATA_W-1:0] ry;

  logic [CW-1:0]            n_eff;
  logic [CW-1:0]            n;
  logic [AW-1:0]            s;
  logic [CW-1:0]            s_ext;
  logic                     found;
  logic                     last;
  logic signed [DATA_W-1:0] qx;
  logic signed [DATA_W-1:0] prev_x;
  logic signed [DATA_W-1:0] prev_y;
  logic signed [DATA_W-1:0] cur_x;
  logic signed [DATA_W-1:0] cur_y;
  logic signed [32:0]       dx;
  logic signed [32:0]       dy;
  logic signed [32:0]       dv;
  logic [31:0]              mdx;
  logic [31:0]              mdy;
  logic [31:0]              mdv;
  logic                     neg;
  logic [63:0]              prod;
  logic                     div_start;
  logic                     div_done;
  logic [63:0]              div_quo;
  logic signed [34:0]       sum;
  logic signed [DATA_W-1:0] res_y;
  logic                     res_sat;
  logic                     out_load;
  logic [DATA_W-1:0]        out_y;
  logic                     out_sat;
  logic                     out_valid;

  pli_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (mdx),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign rx    = ram_rdata[2*DATA_W-1:DATA_W];
  assign ry    = ram_rdata[DATA_W-1:0];
  assign n_eff = (32'(point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);
  assign s_ext = CW'(s);
  assign found = (qx <= rx);
  assign last  = ((s_ext + CW'(1)) == n);
  assign sum   = neg ? (35'(prev_y) - $signed({1'b0, div_quo[33:0]}))
                     : (35'(prev_y) + $signed({1'b0, div_quo[33:0]}));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = AW'(q_cmd.idx);
    ram_wdata  = {q_cmd.px, q_cmd.py};
    ram_raddr  = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.kind == OP_WRITE) begin
            ram_we = 1'b1;
          end else if (n_eff == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = s + AW'(1);
        if (found) begin
          state_next = ((s == '0) || (qx == rx)) ? ST_DONE : ST_DIFF;
        end else if (last) begin
          state_next = ST_DONE;
        end
      end
      ST_DIFF: begin
        state_next = ST_MAG;
      end
      ST_MAG: begin
        state_next = (dx == '0) ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_DSTART;
      end
      ST_DSTART: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        qx      <= q_cmd.qx;
        s       <= '0;
        n       <= n_eff;
        res_y   <= '0;
        res_sat <= 1'b0;
      end
      ST_SCAN: begin
        if (found) begin
          res_y <= ry;
          cur_x <= rx;
          cur_y <= ry;
        end else if (last) begin
          res_y <= ry;
        end else begin
          prev_x <= rx;
          prev_y <= ry;
          s      <= s + AW'(1);
        end
      end
      ST_DIFF: begin
        dx <= {cur_x[31], cur_x} - {prev_x[31], prev_x};
        dy <= {cur_y[31], cur_y} - {prev_y[31], prev_y};
        dv <= {qx[31], qx} - {prev_x[31], prev_x};
      end
      ST_MAG: begin
        res_y <= prev_y;
        mdx   <= dx[32] ? 32'(-dx) : dx[31:0];
        mdy   <= dy[32] ? 32'(-dy) : dy[31:0];
        mdv   <= dv[32] ? 32'(-dv) : dv[31:0];
        neg   <= dx[32] ^ dy[32] ^ dv[32];
      end
      ST_MUL: begin
        prod <= 64'(mdy) * 64'(mdv);
      end
      ST_SUM: begin
        if (div_quo > Q_LIMIT) begin
          res_sat <= 1'b1;
          res_y   <= neg ? SUM_MIN[31:0] : SUM_MAX[31:0];
        end else if (sum > SUM_MAX) begin
          res_sat <= 1'b1;
          res_y   <= SUM_MAX[31:0];
        end else if (sum < SUM_MIN) begin
          res_sat <= 1'b1;
          res_y   <= SUM_MIN[31:0];
        end else begin
          res_y <= sum[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_y   <= res_y;
      out_sat <= res_sat;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_y;
  assign m_tuser  = out_sat;

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE) && q_valid)
    else $error("queue popped outside idle");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (s_ext < n))
    else $error("scan index past table");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside wait");

  a_load_word: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == ST_IDLE))
    else $error("result word not presented");

endmodule
